@@ hdl/triple_bcd_digit_mux_driver_defines.svh @@
// Assertion helpers shared by the driver modules.
`ifndef TRIPLE_BCD_DIGIT_MUX_DRIVER_DEFINES_SVH
`define TRIPLE_BCD_DIGIT_MUX_DRIVER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define TBDM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define TBDM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/tbdm_pkg.sv @@
`timescale 1ns / 1ps

package tbdm_pkg;

  localparam int unsigned ValueW     = 10;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned DisplayMax = 999;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    DIG_HUNDREDS = 2'd0,
    DIG_TENS     = 2'd1,
    DIG_UNITS    = 2'd2
  } digit_e;

  typedef struct packed {
    logic [DigitW-1:0] hun;
    logic [DigitW-1:0] ten;
    logic [DigitW-1:0] one;
  } digits_t;

  typedef struct packed {
    logic    bad;
    logic    dec;
    digits_t a;
    digits_t b;
    digits_t c;
  } entry_t;

endpackage

@@ hdl/tbdm_front.sv @@
`timescale 1ns / 1ps

module tbdm_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tbdm_pkg::ValueW-1:0]   value_a_i,
  input  logic [tbdm_pkg::ValueW-1:0]   value_b_i,
  input  logic [tbdm_pkg::ValueW-1:0]   value_c_i,
  input  logic                          decimal_mode_i,
  input  logic                          full_i,
  output logic                          push_o,
  output tbdm_pkg::entry_t              entry_o
);
  import tbdm_pkg::*;

  function automatic digits_t to_bcd(input logic [ValueW-1:0] v);
    logic [15:0] prod_h;
    logic [3:0]  hun;
    logic [9:0]  hun_x100;
    logic [9:0]  rem_full;
    logic [6:0]  rem;
    logic [14:0] prod_t;
    logic [3:0]  ten;
    logic [6:0]  ten_x10;
    digits_t     d;
    prod_h   = 16'(v) * 16'd41;
    hun      = prod_h[15:12];
    hun_x100 = 10'(hun) * 10'd100;
    rem_full = v - hun_x100;
    rem      = rem_full[6:0];
    prod_t   = 15'(rem) * 15'd205;
    ten      = prod_t[14:11];
    ten_x10  = 7'(ten) * 7'd10;
    d.hun    = hun;
    d.ten    = ten;
    d.one    = 4'(rem - ten_x10);
    return d;
  endfunction

  logic a_over, b_over, c_over;

  always_comb begin
    a_over = value_a_i > ValueW'(DisplayMax);
    b_over = value_b_i > ValueW'(DisplayMax);
    c_over = value_c_i > ValueW'(DisplayMax);
    entry_o.bad = decimal_mode_i ? a_over : (a_over | b_over | c_over);
    entry_o.dec = decimal_mode_i;
    entry_o.a   = to_bcd(value_a_i);
    entry_o.b   = to_bcd(value_b_i);
    entry_o.c   = to_bcd(value_c_i);
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

@@ hdl/tbdm_fifo.sv @@
`timescale 1ns / 1ps
`include "triple_bcd_digit_mux_driver_defines.svh"

module tbdm_fifo #(
  parameter int unsigned Depth = tbdm_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tbdm_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output tbdm_pkg::entry_t head_o
);
  import tbdm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  `TBDM_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth), "queue count overflow")
  `TBDM_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, full_o, !push_i, "push into full queue")
  `TBDM_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, empty_o, !pop_i, "pop from empty queue")

endmodule

@@ hdl/tbdm_back.sv @@
`timescale 1ns / 1ps
`include "triple_bcd_digit_mux_driver_defines.svh"

module tbdm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  tbdm_pkg::entry_t              head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [1:0]                    digit_index_o,
  output logic [tbdm_pkg::DigitW-1:0]   bcd_a_o,
  output logic [tbdm_pkg::DigitW-1:0]   bcd_b_o,
  output logic [tbdm_pkg::DigitW-1:0]   bcd_c_o,
  output logic                          point_lit_o,
  output logic                          last_o
);
  import tbdm_pkg::*;

  digit_e              pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  logic                status_q, status_d;
  digit_e              digit_q, digit_d;
  logic [DigitW-1:0]   bcd_a_q, bcd_a_d;
  logic [DigitW-1:0]   bcd_b_q, bcd_b_d;
  logic [DigitW-1:0]   bcd_c_q, bcd_c_d;
  logic                point_q, point_d;
  logic                last_q, last_d;
  logic                advance, emit;

  function automatic logic [DigitW-1:0] pick(input digits_t d, input digit_e p);
    logic [DigitW-1:0] r;
    unique case (p)
      DIG_HUNDREDS: r = d.hun;
      DIG_TENS:     r = d.ten;
      DIG_UNITS:    r = d.one;
      default:      r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    advance     = !out_valid_q || out_ready_i;
    emit        = advance && !empty_i;
    pop_o       = emit && (head_i.bad || pos_q == DIG_UNITS);
    pos_d       = pos_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      pos_d       = pop_o ? DIG_HUNDREDS : digit_e'(pos_q + 2'd1);
    end
    if (head_i.bad) begin
      status_d = 1'b1;
      digit_d  = DIG_HUNDREDS;
      bcd_a_d  = '0;
      bcd_b_d  = '0;
      bcd_c_d  = '0;
      point_d  = 1'b0;
      last_d   = 1'b1;
    end else begin
      status_d = 1'b0;
      digit_d  = pos_q;
      bcd_a_d  = pick(head_i.a, pos_q);
      bcd_b_d  = pick(head_i.b, pos_q);
      bcd_c_d  = pick(head_i.c, pos_q);
      point_d  = head_i.dec && (pos_q == DIG_TENS);
      last_d   = pos_q == DIG_UNITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= DIG_HUNDREDS;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= status_d;
      digit_q  <= digit_d;
      bcd_a_q  <= bcd_a_d;
      bcd_b_q  <= bcd_b_d;
      bcd_c_q  <= bcd_c_d;
      point_q  <= point_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign digit_index_o = digit_q;
  assign bcd_a_o       = bcd_a_q;
  assign bcd_b_o       = bcd_b_q;
  assign bcd_c_o       = bcd_c_q;
  assign point_lit_o   = point_q;
  assign last_o        = last_q;

  `TBDM_ASSERT_IMP(a_reject_single, clk_i, rst_ni, out_valid_q && status_q,
                   last_q && digit_q == DIG_HUNDREDS, "reject result not single")
  `TBDM_ASSERT_IMP(a_point_tens, clk_i, rst_ni, out_valid_q && point_q,
                   digit_q == DIG_TENS && !status_q, "point lit off tens strobe")
  `TBDM_ASSERT(a_digit_order, clk_i, rst_ni,
               (out_valid_q && out_ready_i && !last_q) |=>
               (!out_valid_q || digit_q == digit_e'($past(digit_q) + 2'd1)),
               "digit strobe out of order")

endmodule

@@ hdl/triple_bcd_digit_mux_driver.sv @@
`timescale 1ns / 1ps

// Takes one request holding three 10-bit display values and a decimal-mode flag and
// returns the digits for three shared-strobe 3-digit displays: hundreds, tens, then
// units, one result per cycle unless out_ready holds the output, with last set on
// the units result. A rejected request (a checked value above 999) returns a single
// result with status set. The request is checked and converted to BCD in the cycle
// it is accepted and lands in a small queue (QueueDepth entries); a sequencer that
// emits one result per cycle unless stalled drains it into a registered output
// stage, so the first result passes through the queue and then the output stage.
// The queue takes new requests, while not full, as the sequencer drains older ones.
module triple_bcd_digit_mux_driver #(
  parameter int unsigned QueueDepth = tbdm_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tbdm_pkg::ValueW-1:0]   value_a_i,
  input  logic [tbdm_pkg::ValueW-1:0]   value_b_i,
  input  logic [tbdm_pkg::ValueW-1:0]   value_c_i,
  input  logic                          decimal_mode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [1:0]                    digit_index_o,
  output logic [tbdm_pkg::DigitW-1:0]   bcd_a_o,
  output logic [tbdm_pkg::DigitW-1:0]   bcd_b_o,
  output logic [tbdm_pkg::DigitW-1:0]   bcd_c_o,
  output logic                          point_lit_o,
  output logic                          last_o
);
  import tbdm_pkg::*;

  logic   push, pop, full, empty;
  entry_t in_entry, head;

  tbdm_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_a_i      (value_a_i),
    .value_b_i      (value_b_i),
    .value_c_i      (value_c_i),
    .decimal_mode_i (decimal_mode_i),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (in_entry)
  );

  tbdm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (in_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  tbdm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .digit_index_o (digit_index_o),
    .bcd_a_o       (bcd_a_o),
    .bcd_b_o       (bcd_b_o),
    .bcd_c_o       (bcd_c_o),
    .point_lit_o   (point_lit_o),
    .last_o        (last_o)
  );

endmodule
